FILE: rtl/core/gregorian_day_number_converter_assert.svh
// Concurrent check macros for the day number converter.
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define GDNC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdnc: same-cycle check failed");
`define GDNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdnc: next-cycle check failed");
`else
`define GDNC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GDNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/gdnc_pkg.sv
package gdnc_pkg;

  localparam int DN_W   = 22;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int NTH_W  = 4;
  localparam int WD_W   = 3;
  localparam int OP_W   = 2;
  localparam int DOY_W  = 9;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
  localparam logic [MON_W-1:0]  LAST_MONTH = 4'd12;
  localparam logic [WD_W-1:0]   LAST_WEEKDAY = 3'd6;

  // Last day of the last supported year.
  localparam logic [DN_W-1:0] MAX_DAY = DN_W'(int'(MAX_YEAR) * 365 + int'(MAX_YEAR) / 4
                                              - int'(MAX_YEAR) / 100 + int'(MAX_YEAR) / 400);

  typedef enum logic [OP_W-1:0] {
    OP_TO_DAY  = 2'd0,
    OP_TO_DATE = 2'd1,
    OP_NTH     = 2'd2,
    OP_BAD     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_DIV,
    ST_T_MUL,
    ST_T_SUM,
    ST_FIX,
    ST_NTH_MOD,
    ST_NTH_ADD,
    ST_EST,
    ST_Y_DIV,
    ST_Y_MUL,
    ST_Y_SUM,
    ST_Y_CHK,
    ST_MON,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic yb_div;
    logic yb_mul;
    logic yb_sum;
    logic fix;
    logic nth_mod;
    logic nth_add;
    logic est;
    logic y_chk;
    logic mon_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic year_found;
    logic mon_more;
    logic out_free;
  } stat_t;

  // Days in the year before the first of a month.
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] month,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    unique case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + {8'b0, (leap && (month > 4'd2))};
  endfunction

  function automatic logic [DAY_W-1:0] last_day(input logic [MON_W-1:0] month,
                                                input logic leap);
    logic [DAY_W-1:0] ld;
    unique case (month)
      4'd2:                      ld = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   ld = 5'd30;
      default:                   ld = 5'd31;
    endcase
    return ld;
  endfunction

  // Residue mod 7 by folding octal digits (8 = 1 mod 7).
  function automatic logic [2:0] mod7(input logic [23:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
       + 6'(v[14:12]) + 6'(v[17:15]) + 6'(v[20:18]) + 6'(v[23:21]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

endpackage

FILE: rtl/core/gdnc_ctrl.sv
module gdnc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  gdnc_pkg::op_e   in_op_i,
  input  gdnc_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output gdnc_pkg::cmd_t  cmd_o
);

  gdnc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdnc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdnc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            gdnc_pkg::OP_TO_DAY,
            gdnc_pkg::OP_NTH:     state_d = gdnc_pkg::ST_T_DIV;
            gdnc_pkg::OP_TO_DATE: state_d = gdnc_pkg::ST_EST;
            default:              state_d = gdnc_pkg::ST_DONE;
          endcase
        end
      end
      gdnc_pkg::ST_T_DIV:   state_d = gdnc_pkg::ST_T_MUL;
      gdnc_pkg::ST_T_MUL:   state_d = gdnc_pkg::ST_T_SUM;
      gdnc_pkg::ST_T_SUM:   state_d = gdnc_pkg::ST_FIX;
      gdnc_pkg::ST_FIX: begin
        state_d = (stat_i.op == gdnc_pkg::OP_NTH) ? gdnc_pkg::ST_NTH_MOD : gdnc_pkg::ST_DONE;
      end
      gdnc_pkg::ST_NTH_MOD: state_d = gdnc_pkg::ST_NTH_ADD;
      gdnc_pkg::ST_NTH_ADD: state_d = gdnc_pkg::ST_EST;
      gdnc_pkg::ST_EST:     state_d = gdnc_pkg::ST_Y_DIV;
      gdnc_pkg::ST_Y_DIV:   state_d = gdnc_pkg::ST_Y_MUL;
      gdnc_pkg::ST_Y_MUL:   state_d = gdnc_pkg::ST_Y_SUM;
      gdnc_pkg::ST_Y_SUM:   state_d = gdnc_pkg::ST_Y_CHK;
      gdnc_pkg::ST_Y_CHK: begin
        state_d = stat_i.year_found ? gdnc_pkg::ST_MON : gdnc_pkg::ST_Y_DIV;
      end
      gdnc_pkg::ST_MON: begin
        if (!stat_i.mon_more) begin
          state_d = gdnc_pkg::ST_DONE;
        end
      end
      gdnc_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = gdnc_pkg::ST_IDLE;
        end
      end
      default: state_d = gdnc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == gdnc_pkg::ST_IDLE);
    unique case (state_q)
      gdnc_pkg::ST_IDLE:    cmd_o.load_in  = in_valid_i;
      gdnc_pkg::ST_T_DIV,
      gdnc_pkg::ST_Y_DIV:   cmd_o.yb_div   = 1'b1;
      gdnc_pkg::ST_T_MUL,
      gdnc_pkg::ST_Y_MUL:   cmd_o.yb_mul   = 1'b1;
      gdnc_pkg::ST_T_SUM,
      gdnc_pkg::ST_Y_SUM:   cmd_o.yb_sum   = 1'b1;
      gdnc_pkg::ST_FIX:     cmd_o.fix      = 1'b1;
      gdnc_pkg::ST_NTH_MOD: cmd_o.nth_mod  = 1'b1;
      gdnc_pkg::ST_NTH_ADD: cmd_o.nth_add  = 1'b1;
      gdnc_pkg::ST_EST:     cmd_o.est      = 1'b1;
      gdnc_pkg::ST_Y_CHK:   cmd_o.y_chk    = 1'b1;
      gdnc_pkg::ST_MON:     cmd_o.mon_step = 1'b1;
      gdnc_pkg::ST_DONE:    cmd_o.load_out = stat_i.out_free;
      default:              cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/gdnc_dp.sv
module gdnc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gdnc_pkg::cmd_t                  cmd_i,
  input  gdnc_pkg::op_e                   op_i,
  input  logic [gdnc_pkg::DN_W-1:0]       day_number_i,
  input  logic [gdnc_pkg::YEAR_W-1:0]     year_i,
  input  logic [gdnc_pkg::MON_W-1:0]      month_i,
  input  logic [gdnc_pkg::DAY_W-1:0]      day_i,
  input  logic signed [gdnc_pkg::NTH_W-1:0] nth_i,
  input  logic [gdnc_pkg::WD_W-1:0]       weekday_i,
  input  logic                            out_ready_i,
  output gdnc_pkg::stat_t                 stat_o,
  output logic                            out_valid_o,
  output logic [gdnc_pkg::DN_W-1:0]       day_number_o,
  output logic [gdnc_pkg::YEAR_W-1:0]     year_o,
  output logic [gdnc_pkg::MON_W-1:0]      month_o,
  output logic [gdnc_pkg::DAY_W-1:0]      day_o,
  output logic [gdnc_pkg::WD_W-1:0]       weekday_o,
  output logic                            out_of_range_o
);

  // floor(2^32 / 365.2425), year estimate from a day count
  localparam logic [23:0] YrRecip = 24'((64'd1 << 32) * 64'd400 / 64'd146097);
  // x / 100 == (x * 5243) >> 19 for x below 43699
  localparam logic [26:0] HundRecip = 27'd5243;

  // working registers
  gdnc_pkg::op_e                   op_q;
  logic [gdnc_pkg::DN_W-1:0]       f_q;
  logic [gdnc_pkg::YEAR_W-1:0]     yr_q;
  logic [gdnc_pkg::MON_W-1:0]      mo_q;
  logic [gdnc_pkg::DAY_W-1:0]      dy_q;
  logic signed [gdnc_pkg::NTH_W-1:0] n_q;
  logic [gdnc_pkg::WD_W-1:0]       x_q;
  logic                            flag_q;
  logic [7:0]                      q_q;
  logic                            rz_q;
  logic                            leap_q;
  logic [22:0]                     prod_q;
  logic [22:0]                     base_q;
  logic [2:0]                      m7_q;
  logic [gdnc_pkg::DOY_W-1:0]      doy_q;

  // result register
  logic                            out_valid_q;
  logic [gdnc_pkg::DN_W-1:0]       out_dn_q;
  logic [gdnc_pkg::YEAR_W-1:0]     out_yr_q;
  logic [gdnc_pkg::MON_W-1:0]      out_mo_q;
  logic [gdnc_pkg::DAY_W-1:0]      out_dy_q;
  logic [gdnc_pkg::WD_W-1:0]       out_wd_q;
  logic                            out_flag_q;

  // input clamp
  logic [gdnc_pkg::DN_W-1:0]   dn_cl;
  logic [gdnc_pkg::YEAR_W-1:0] y_cl;
  logic [gdnc_pkg::MON_W-1:0]  m_cl;
  logic [gdnc_pkg::WD_W-1:0]   x_cl;
  logic                        dn_flag, y_flag, m_flag, x_flag, in_flag;

  always_comb begin
    dn_cl   = day_number_i;
    dn_flag = 1'b0;
    if (day_number_i == '0) begin
      dn_cl   = 22'd1;
      dn_flag = 1'b1;
    end else if (day_number_i > gdnc_pkg::MAX_DAY) begin
      dn_cl   = gdnc_pkg::MAX_DAY;
      dn_flag = 1'b1;
    end
    y_cl   = year_i;
    y_flag = 1'b0;
    if (year_i == '0) begin
      y_cl   = 14'd1;
      y_flag = 1'b1;
    end else if (year_i > gdnc_pkg::MAX_YEAR) begin
      y_cl   = gdnc_pkg::MAX_YEAR;
      y_flag = 1'b1;
    end
    m_cl   = month_i;
    m_flag = 1'b0;
    if (month_i == '0) begin
      m_cl   = 4'd1;
      m_flag = 1'b1;
    end else if (month_i > gdnc_pkg::LAST_MONTH) begin
      m_cl   = gdnc_pkg::LAST_MONTH;
      m_flag = 1'b1;
    end
    x_flag = (weekday_i > gdnc_pkg::LAST_WEEKDAY);
    x_cl   = x_flag ? gdnc_pkg::LAST_WEEKDAY : weekday_i;
    if (op_i == gdnc_pkg::OP_TO_DATE) begin
      in_flag = dn_flag;
    end else begin
      in_flag = y_flag | m_flag | (x_flag & (op_i == gdnc_pkg::OP_NTH));
    end
  end

  // year base unit: days before Jan 1 of yr_q, and its leap bit
  logic [26:0]                 div_prod;
  logic [gdnc_pkg::YEAR_W-1:0] hund;
  logic [gdnc_pkg::YEAR_W-1:0] r100;
  logic                        rz;
  logic                        leap;
  logic [gdnc_pkg::YEAR_W-1:0] pm1;
  logic [22:0]                 prod;
  logic [7:0]                  p100;
  logic [5:0]                  p400;
  logic [22:0]                 base;

  assign div_prod = 27'(yr_q) * HundRecip;
  assign hund     = {6'b0, q_q} * 14'd100;
  assign r100     = yr_q - hund;
  assign rz       = (r100 == '0);
  assign leap     = ((yr_q[1:0] == 2'd0) && !rz) || (rz && (q_q[1:0] == 2'd0));
  assign pm1      = yr_q - 14'd1;
  assign prod     = {9'b0, pm1} * 23'd365 + {11'b0, pm1[13:2]};
  assign p100     = q_q - {7'b0, rz_q};
  assign p400     = q_q[7:2] - {5'b0, (rz_q && (q_q[1:0] == 2'd0))};
  assign base     = prod_q - {15'b0, p100} + {17'b0, p400};

  // date to day number
  logic                        n_pos;
  logic [gdnc_pkg::DAY_W-1:0]  ld;
  logic [gdnc_pkg::DAY_W-1:0]  d_fix;
  logic                        d_flag;
  logic [gdnc_pkg::DN_W-1:0]   f_fix;

  assign n_pos = !n_q[gdnc_pkg::NTH_W-1] && (n_q != '0);
  assign ld    = gdnc_pkg::last_day(mo_q, leap_q);

  always_comb begin
    d_fix  = dy_q;
    d_flag = 1'b0;
    if (dy_q == '0 && op_q == gdnc_pkg::OP_NTH) begin
      d_fix = n_pos ? 5'd1 : ld;
    end else if (dy_q == '0) begin
      d_fix  = 5'd1;
      d_flag = 1'b1;
    end else if (dy_q > ld) begin
      d_fix  = ld;
      d_flag = 1'b1;
    end
  end

  assign f_fix = 22'(base_q + {14'b0, gdnc_pkg::days_before(mo_q, leap_q)} + {18'b0, d_fix});

  // nth weekday
  logic [22:0]        g;
  logic [2:0]         m7;
  logic signed [7:0]  n_s;
  logic signed [7:0]  k;
  logic signed [7:0]  k7;
  logic signed [24:0] r;
  logic [gdnc_pkg::DN_W-1:0] r_cl;
  logic               r_flag;

  assign g   = {1'b0, f_q} + (n_pos ? 23'd6 : 23'd0);
  assign m7  = gdnc_pkg::mod7({1'b0, g} + 24'd7 - {21'b0, x_q});
  assign n_s = {{4{n_q[gdnc_pkg::NTH_W-1]}}, n_q};
  assign k   = n_pos ? (n_s - 8'sd1) : (n_s + 8'sd1);
  assign k7  = (k <<< 3) - k;
  assign r   = $signed({3'b0, f_q}) - $signed({22'b0, m7_q}) + $signed({{17{k7[7]}}, k7});

  always_comb begin
    r_cl   = r[gdnc_pkg::DN_W-1:0];
    r_flag = 1'b0;
    if (r < 25'sd1) begin
      r_cl   = 22'd1;
      r_flag = 1'b1;
    end else if (r > $signed({3'b0, gdnc_pkg::MAX_DAY})) begin
      r_cl   = gdnc_pkg::MAX_DAY;
      r_flag = 1'b1;
    end
  end

  // day number to date
  logic [45:0]                 est_prod;
  logic                        year_found;
  logic [gdnc_pkg::DOY_W-1:0]  db_next;
  logic                        mon_more;

  assign est_prod   = {24'b0, (f_q - 22'd1)} * {22'b0, YrRecip};
  assign year_found = ({1'b0, f_q} > base_q);
  assign db_next    = gdnc_pkg::days_before(mo_q + 4'd1, leap_q);
  assign mon_more   = (mo_q < gdnc_pkg::LAST_MONTH) && (doy_q > db_next);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_i;
      f_q    <= dn_cl;
      yr_q   <= y_cl;
      mo_q   <= m_cl;
      dy_q   <= day_i;
      n_q    <= nth_i;
      x_q    <= x_cl;
      flag_q <= in_flag;
    end
    if (cmd_i.yb_div) begin
      q_q <= div_prod[26:19];
    end
    if (cmd_i.yb_mul) begin
      rz_q   <= rz;
      leap_q <= leap;
      prod_q <= prod;
    end
    if (cmd_i.yb_sum) begin
      base_q <= base;
    end
    if (cmd_i.fix) begin
      dy_q   <= d_fix;
      f_q    <= f_fix;
      flag_q <= flag_q | d_flag;
    end
    if (cmd_i.nth_mod) begin
      f_q  <= g[gdnc_pkg::DN_W-1:0];
      m7_q <= m7;
    end
    if (cmd_i.nth_add) begin
      f_q    <= r_cl;
      flag_q <= flag_q | r_flag;
    end
    if (cmd_i.est) begin
      yr_q <= est_prod[45:32] + 14'd3;  // upper bound, search walks down
    end
    if (cmd_i.y_chk) begin
      if (year_found) begin
        doy_q <= 9'(f_q - base_q[gdnc_pkg::DN_W-1:0]);
        mo_q  <= 4'd1;
      end else begin
        yr_q <= yr_q - 14'd1;
      end
    end
    if (cmd_i.mon_step) begin
      if (mon_more) begin
        mo_q <= mo_q + 4'd1;
      end else begin
        dy_q <= 5'(doy_q - gdnc_pkg::days_before(mo_q, leap_q));
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (op_q == gdnc_pkg::OP_BAD) begin
        out_dn_q   <= '0;
        out_yr_q   <= '0;
        out_mo_q   <= '0;
        out_dy_q   <= '0;
        out_wd_q   <= '0;
        out_flag_q <= 1'b1;
      end else begin
        out_dn_q   <= f_q;
        out_yr_q   <= yr_q;
        out_mo_q   <= mo_q;
        out_dy_q   <= dy_q;
        out_wd_q   <= gdnc_pkg::mod7({2'b0, f_q});
        out_flag_q <= flag_q;
      end
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.year_found = year_found;
  assign stat_o.mon_more   = mon_more;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign day_number_o   = out_dn_q;
  assign year_o         = out_yr_q;
  assign month_o        = out_mo_q;
  assign day_o          = out_dy_q;
  assign weekday_o      = out_wd_q;
  assign out_of_range_o = out_flag_q;

endmodule

FILE: rtl/core/gregorian_day_number_converter.sv
// Channel   Dir  tdata                                           tuser
// s_axis    in   day_number, year_in, month_in, day_in, nth,     operation
//                weekday_in (56 bits, zero padded)
// m_axis    out  day_number_out, year_out, month_out, day_out,   out_of_range
//                weekday_out (48 bits)
//
// One item at a time. Op 1 and op 2 search Y = 2..4 year candidates (each one
//   pass of the year base unit, divide, multiply and sum, plus a compare) and
//   M = 1..12 month steps.
// Reset only clears the controller and the output valid; no state survives an item.
// The output register frees the core as soon as a result is stored, so a stalled
// m_axis holds at most one finished result while the next item is in work.
`include "gregorian_day_number_converter_assert.svh"

module gregorian_day_number_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [21:0] day_number, [35:22] year_in, [39:36] month_in, [44:40] day_in,
  // [48:45] nth, [51:49] weekday_in, [55:52] zero
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [21:0] day_number_out, [35:22] year_out, [39:36] month_out, [44:40] day_out,
  // [47:45] weekday_out
  output logic [47:0] m_axis_tdata_o,
  // [0] out_of_range
  output logic        m_axis_tuser_o
);

  gdnc_pkg::cmd_t  cmd;
  gdnc_pkg::stat_t stat;
  gdnc_pkg::op_e   in_op;

  logic [gdnc_pkg::DN_W-1:0]   dn_out;
  logic [gdnc_pkg::YEAR_W-1:0] yr_out;
  logic [gdnc_pkg::MON_W-1:0]  mo_out;
  logic [gdnc_pkg::DAY_W-1:0]  dy_out;
  logic [gdnc_pkg::WD_W-1:0]   wd_out;

  assign in_op = gdnc_pkg::op_e'(s_axis_tuser_i);

  // Sequencer: walks each operation through the shared year base unit,
  // the weekday adjust, the year search and the month search.
  gdnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (in_op),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  // Datapath: clamps, day count arithmetic and the result register.
  gdnc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (in_op),
    .day_number_i   (s_axis_tdata_i[21:0]),
    .year_i         (s_axis_tdata_i[35:22]),
    .month_i        (s_axis_tdata_i[39:36]),
    .day_i          (s_axis_tdata_i[44:40]),
    .nth_i          ($signed(s_axis_tdata_i[48:45])),
    .weekday_i      (s_axis_tdata_i[51:49]),
    .out_ready_i    (m_axis_tready_i),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid_o),
    .day_number_o   (dn_out),
    .year_o         (yr_out),
    .month_o        (mo_out),
    .day_o          (dy_out),
    .weekday_o      (wd_out),
    .out_of_range_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o[21:0]  = dn_out;
  assign m_axis_tdata_o[35:22] = yr_out;
  assign m_axis_tdata_o[39:36] = mo_out;
  assign m_axis_tdata_o[44:40] = dy_out;
  assign m_axis_tdata_o[47:45] = wd_out;

  // Core goes busy right after it takes an item.
  `GDNC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // An unflagged result always has a nonzero day and a month from 1 to 12.
  `GDNC_ASSERT_IMPL(a_result_is_date, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, (m_axis_tdata_o[44:40] != 5'd0) && (m_axis_tdata_o[39:36] != 4'd0) && (m_axis_tdata_o[39:36] <= 4'd12))
  // Weekday residue never reaches seven.
  `GDNC_ASSERT_IMPL(a_weekday_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[47:45] != 3'd7)

endmodule
